FILE: sv/assert_macros.svh
// assertion macros shared by the voxelizer rtl
// every macro samples on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

FILE: sv/tdv_pkg.sv
// package for the trilinear density voxelizer
// types, field widths and default grid geometry; no dependencies
package tdv_pkg;

  localparam int GRID_XZ_DEF = 5;
  localparam int GRID_Y_DEF  = 17;
  localparam int CELL_XZ_DEF = 4;
  localparam int CELL_Y_DEF  = 8;

  localparam int SAMPLE_W     = 24;
  localparam int INDEX_W      = 9;
  localparam int POS_X_W      = 4;
  localparam int POS_Y_W      = 7;
  localparam int POS_Z_W      = 4;
  localparam int TILE_W       = 8;
  localparam int TILE_INDEX_W = POS_X_W + POS_Z_W + POS_Y_W;
  localparam int CORNERS      = 8;
  localparam int LATENCY      = 6;

  localparam logic [TILE_W-1:0] ROCK_ID_RST = 8'd1;

  typedef enum logic [0:0] {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e                   req_type;
    logic [INDEX_W-1:0]          sample_index;
    logic signed [SAMPLE_W-1:0]  sample_value;
    logic [POS_X_W-1:0]          pos_x;
    logic [POS_Y_W-1:0]          pos_y;
    logic [POS_Z_W-1:0]          pos_z;
  } req_t;

  typedef struct packed {
    logic [TILE_W-1:0]       tile_id;
    logic [TILE_INDEX_W-1:0] tile_index;
  } rsp_t;

  typedef struct packed {
    logic [POS_X_W-1:0] fx;
    logic [POS_Y_W-1:0] fy;
    logic [POS_Z_W-1:0] fz;
  } frac_t;

  typedef struct packed {
    logic                    valid;
    frac_t                   frac;
    logic [TILE_INDEX_W-1:0] tile_index;
  } qry_t;

endpackage

FILE: sv/tdv_addr.sv
// corner address generation: cell, fraction and clamped grid address per corner
// depends on tdv_pkg
module tdv_addr #(
  parameter int GRID_XZ = tdv_pkg::GRID_XZ_DEF,
  parameter int GRID_Y  = tdv_pkg::GRID_Y_DEF,
  parameter int CELL_XZ = tdv_pkg::CELL_XZ_DEF,
  parameter int CELL_Y  = tdv_pkg::CELL_Y_DEF,
  parameter int ADDR_W  = 9
) (
  input  tdv_pkg::req_t                              req_i,
  output logic [tdv_pkg::CORNERS-1:0][ADDR_W-1:0]    addr_o,
  output tdv_pkg::frac_t                             frac_o
);

  localparam logic [7:0] LAST_XZ = 8'(GRID_XZ - 1);
  localparam logic [7:0] LAST_Y  = 8'(GRID_Y - 1);
  localparam int         NX      = 1 << tdv_pkg::POS_X_W;
  localparam int         NY      = 1 << tdv_pkg::POS_Y_W;
  localparam int         NZ      = 1 << tdv_pkg::POS_Z_W;

  logic [7:0] cx, cy, cz;

  // cell and fraction lookup tables, one entry per fine position
  logic [7:0]                   cx_tab [NX];
  logic [tdv_pkg::POS_X_W-1:0]  fx_tab [NX];
  logic [7:0]                   cy_tab [NY];
  logic [tdv_pkg::POS_Y_W-1:0]  fy_tab [NY];
  logic [7:0]                   cz_tab [NZ];
  logic [tdv_pkg::POS_Z_W-1:0]  fz_tab [NZ];

  for (genvar p = 0; p < NX; p++) begin : g_xtab
    assign cx_tab[p] = 8'(p / CELL_XZ);
    assign fx_tab[p] = tdv_pkg::POS_X_W'(p % CELL_XZ);
  end

  for (genvar p = 0; p < NY; p++) begin : g_ytab
    assign cy_tab[p] = 8'(p / CELL_Y);
    assign fy_tab[p] = tdv_pkg::POS_Y_W'(p % CELL_Y);
  end

  for (genvar p = 0; p < NZ; p++) begin : g_ztab
    assign cz_tab[p] = 8'(p / CELL_XZ);
    assign fz_tab[p] = tdv_pkg::POS_Z_W'(p % CELL_XZ);
  end

  always_comb begin
    cx        = cx_tab[req_i.pos_x];
    cy        = cy_tab[req_i.pos_y];
    cz        = cz_tab[req_i.pos_z];
    frac_o.fx = fx_tab[req_i.pos_x];
    frac_o.fy = fy_tab[req_i.pos_y];
    frac_o.fz = fz_tab[req_i.pos_z];
  end

  for (genvar k = 0; k < tdv_pkg::CORNERS; k++) begin : g_corner
    localparam logic [7:0] DX = 8'((k >> 2) & 1);
    localparam logic [7:0] DY = 8'((k >> 1) & 1);
    localparam logic [7:0] DZ = 8'(k & 1);

    logic [7:0] ux, uy, uz;
    logic [7:0] gx, gy, gz;

    always_comb begin
      ux = cx + DX;
      uy = cy + DY;
      uz = cz + DZ;
      // upper corner saturates at the last grid plane
      gx = (ux > LAST_XZ) ? LAST_XZ : ux;
      gy = (uy > LAST_Y)  ? LAST_Y  : uy;
      gz = (uz > LAST_XZ) ? LAST_XZ : uz;
      addr_o[k] = ADDR_W'((ADDR_W'(gx) * ADDR_W'(GRID_XZ) + ADDR_W'(gz)) * ADDR_W'(GRID_Y)
                          + ADDR_W'(gy));
    end
  end

endmodule

FILE: sv/tdv_grid.sv
// density grid storage: eight identical copies, one read port per corner
// loads write every copy; depends on tdv_pkg and assert_macros.svh
`include "assert_macros.svh"

module tdv_grid #(
  parameter int GRID_SIZE = 425,
  parameter int ADDR_W    = 9
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               we_i,
  input  logic [ADDR_W-1:0]                                  wr_addr_i,
  input  logic signed [tdv_pkg::SAMPLE_W-1:0]                wr_data_i,
  input  logic                                               re_i,
  input  logic [tdv_pkg::CORNERS-1:0][ADDR_W-1:0]            rd_addr_i,
  output logic [tdv_pkg::CORNERS-1:0][tdv_pkg::SAMPLE_W-1:0] rd_data_o
);

  for (genvar k = 0; k < tdv_pkg::CORNERS; k++) begin : g_copy
    logic [tdv_pkg::SAMPLE_W-1:0] mem_q [GRID_SIZE];
    logic [tdv_pkg::SAMPLE_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (we_i) begin
        mem_q[wr_addr_i] <= wr_data_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (re_i) begin
        rd_q <= mem_q[rd_addr_i[k]];
      end
    end

    assign rd_data_o[k] = rd_q;
  end

  // a load and a query never share an edge, so no read-write collision
  `ASSERT_NEVER(a_no_rw_collision, we_i && re_i, "grid written and read in one cycle")

endmodule

FILE: sv/tdv_interp.sv
// trilinear weighting pipeline: corner weights, products, adder tree, sign test
// depends on tdv_pkg
module tdv_interp #(
  parameter int CELL_XZ = tdv_pkg::CELL_XZ_DEF,
  parameter int CELL_Y  = tdv_pkg::CELL_Y_DEF
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  tdv_pkg::qry_t                                      qry_i,
  input  logic [tdv_pkg::CORNERS-1:0][tdv_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [tdv_pkg::TILE_W-1:0]                         rock_id_i,
  output logic                                               strobe_o,
  output tdv_pkg::rsp_t                                      rsp_o
);

  localparam int WXZ_W = $clog2(CELL_XZ + 1);
  localparam int WY_W  = $clog2(CELL_Y + 1);
  localparam int WXY_W = WXZ_W + WY_W;
  localparam int P_W   = tdv_pkg::SAMPLE_W + WXZ_W + 1;
  localparam int Q_W   = P_W + WXY_W;
  localparam int ACC_W = Q_W + 3;
  localparam int LAT   = tdv_pkg::LATENCY;

  logic [LAT-1:0]                      vld_q, vld_d;
  logic [tdv_pkg::TILE_INDEX_W-1:0]    idx_q [LAT];
  tdv_pkg::frac_t                      frac_q;

  logic signed [P_W-1:0]   p_q   [tdv_pkg::CORNERS];
  logic [WXY_W-1:0]        wxy_q [tdv_pkg::CORNERS];
  logic signed [Q_W-1:0]   q_q   [tdv_pkg::CORNERS];
  logic signed [ACC_W-1:0] s4_q  [4];
  logic signed [ACC_W-1:0] s2_q  [2];
  logic signed [ACC_W-1:0] acc;
  logic [tdv_pkg::TILE_W-1:0] tile_q, tile_d;

  assign vld_d = {vld_q[LAT-2:0], qry_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // index and fraction capture at the transfer edge
  always_ff @(posedge clk_i) begin
    idx_q[0] <= qry_i.tile_index;
    for (int i = 1; i < LAT; i++) begin
      idx_q[i] <= idx_q[i-1];
    end
    if (qry_i.valid) begin
      frac_q <= qry_i.frac;
    end
  end

  for (genvar k = 0; k < tdv_pkg::CORNERS; k++) begin : g_corner
    logic [WXZ_W-1:0] wx, wz;
    logic [WY_W-1:0]  wy;

    always_comb begin
      wx = ((k >> 2) & 1) != 0 ? WXZ_W'(frac_q.fx) : WXZ_W'(CELL_XZ) - WXZ_W'(frac_q.fx);
      wy = ((k >> 1) & 1) != 0 ? WY_W'(frac_q.fy)  : WY_W'(CELL_Y) - WY_W'(frac_q.fy);
      wz = (k & 1) != 0        ? WXZ_W'(frac_q.fz) : WXZ_W'(CELL_XZ) - WXZ_W'(frac_q.fz);
    end

    always_ff @(posedge clk_i) begin
      p_q[k]   <= P_W'($signed(sample_i[k])) * P_W'($signed({1'b0, wz}));
      wxy_q[k] <= WXY_W'(wx) * WXY_W'(wy);
      q_q[k]   <= Q_W'(p_q[k]) * Q_W'($signed({1'b0, wxy_q[k]}));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      s4_q[j] <= ACC_W'(q_q[2*j]) + ACC_W'(q_q[2*j+1]);
    end
    for (int j = 0; j < 2; j++) begin
      s2_q[j] <= s4_q[2*j] + s4_q[2*j+1];
    end
    tile_q <= tile_d;
  end

  always_comb begin
    acc    = s2_q[0] + s2_q[1];
    tile_d = (!acc[ACC_W-1] && (acc != '0)) ? rock_id_i : '0;
  end

  assign strobe_o         = vld_q[LAT-1];
  assign rsp_o.tile_id    = tile_q;
  assign rsp_o.tile_index = idx_q[LAT-1];

endmodule

FILE: sv/trilinear_density_voxelizer.sv
// top level of the trilinear density voxelizer
// depends on tdv_pkg, tdv_addr, tdv_grid, tdv_interp and assert_macros.svh
//
// Takes one item per clock: busy is never raised, so start may be held high
// and a new load or query is taken at every edge. A load writes one grid
// sample if sample_index is inside the grid, and gives no result. A query
// gives exactly one result on result_o, marked by strobe_o for a single cycle;
// the receiver cannot stall it and must take it in that cycle. One item per clock
// comes from the grid memory being held in eight identical copies, one read
// port per cube corner, so all eight samples of a query arrive together.
// The grid needs no clearing after reset; a query must only touch samples
// loaded since reset. rock_id writes are always taken (cfg_ready_o high).
`include "assert_macros.svh"

module trilinear_density_voxelizer #(
  parameter int GRID_XZ = tdv_pkg::GRID_XZ_DEF,
  parameter int GRID_Y  = tdv_pkg::GRID_Y_DEF,
  parameter int CELL_XZ = tdv_pkg::CELL_XZ_DEF,
  parameter int CELL_Y  = tdv_pkg::CELL_Y_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  tdv_pkg::req_t                 req_i,
  output logic                          strobe_o,
  output tdv_pkg::rsp_t                 result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tdv_pkg::TILE_W-1:0]    cfg_data_i
);

  localparam int GRID_SIZE = GRID_XZ * GRID_XZ * GRID_Y;
  localparam int ADDR_W    = $clog2(GRID_SIZE);

  logic                                             accept;
  logic                                             load_we;
  logic                                             query_re;
  logic [tdv_pkg::TILE_W-1:0]                       rock_id_q;
  logic [tdv_pkg::CORNERS-1:0][ADDR_W-1:0]          rd_addr;
  logic [tdv_pkg::CORNERS-1:0][tdv_pkg::SAMPLE_W-1:0] rd_data;
  tdv_pkg::frac_t                                   frac;
  tdv_pkg::qry_t                                    qry;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign load_we     = accept && (req_i.req_type == tdv_pkg::REQ_LOAD)
                       && (int'(req_i.sample_index) < GRID_SIZE);
  assign query_re    = accept && (req_i.req_type == tdv_pkg::REQ_QUERY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rock_id_q <= tdv_pkg::ROCK_ID_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rock_id_q <= cfg_data_i;
    end
  end

  tdv_addr #(
    .GRID_XZ (GRID_XZ),
    .GRID_Y  (GRID_Y),
    .CELL_XZ (CELL_XZ),
    .CELL_Y  (CELL_Y),
    .ADDR_W  (ADDR_W)
  ) u_addr (
    .req_i  (req_i),
    .addr_o (rd_addr),
    .frac_o (frac)
  );

  tdv_grid #(
    .GRID_SIZE (GRID_SIZE),
    .ADDR_W    (ADDR_W)
  ) u_grid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (load_we),
    .wr_addr_i (ADDR_W'(req_i.sample_index)),
    .wr_data_i (req_i.sample_value),
    .re_i      (query_re),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    qry.valid      = query_re;
    qry.frac       = frac;
    qry.tile_index = {req_i.pos_x, req_i.pos_z, req_i.pos_y};
  end

  tdv_interp #(
    .CELL_XZ (CELL_XZ),
    .CELL_Y  (CELL_Y)
  ) u_interp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .qry_i     (qry),
    .sample_i  (rd_data),
    .rock_id_i (rock_id_q),
    .strobe_o  (strobe_o),
    .rsp_o     (result_o)
  );

  `ASSERT_CLK(a_query_gives_result, query_re |-> ##(tdv_pkg::LATENCY) strobe_o, "query lost")
  `ASSERT_CLK(a_load_gives_none, (accept && !query_re) |-> ##(tdv_pkg::LATENCY) !strobe_o, "result from a load")
  `ASSERT_CLK(a_tile_id_legal, strobe_o |-> (result_o.tile_id == '0 || result_o.tile_id == rock_id_q), "bad tile id")
  `ASSERT_CLK(a_index_follows, strobe_o |-> (result_o.tile_index == $past(qry.tile_index, tdv_pkg::LATENCY)), "tile index out of order")

endmodule
